// ----- src/hs_pkg.sv -----
// Shared constants, types and helpers for the heap sorter.
package hs_pkg;

  localparam int DATA_W    = 32;
  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = IDX_W + 1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BUILD,
    ST_BVAL,
    ST_SORT,
    ST_SWAP,
    ST_CMP,
    ST_PLACE,
    ST_OUT_RD,
    ST_OUT
  } hs_state_t;

  // Signed greater-than on raw stored words.
  function automatic logic value_gt(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    return $signed(a) > $signed(b);
  endfunction

endpackage

// ----- src/hs_if.sv -----
// Valid/ready channel interfaces for heap sorter input and result streams.
interface hs_in_if import hs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

interface hs_out_if import hs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     last_res;
  logic                     overflow;

  modport source (output valid, sorted_value, last_res, overflow, input ready);
  modport sink   (input valid, sorted_value, last_res, overflow, output ready);
endinterface

// ----- src/hs_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
module hs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- src/heap_sort_top.sv -----
// Heap sorter top level: load, heap build, sort down and result streaming.
//
// Usage: values arrive on the items channel (value, last) and are stored in
// a 64-entry RAM until a request with last set arrives. Values past the
// capacity are dropped; their last mark still closes the batch. The batch
// is then heap sorted in place and streamed on the results channel in
// ascending order, last_res on the final one, overflow on every result of
// a batch that lost values.
// Timing: loading takes one request per cycle. Each sift-down descends one
// heap level per cycle (both children come from the two RAM read ports
// together), after the setup states BUILD and BVAL, or SORT and SWAP.
// Results then leave at one per cycle while the receiver is ready. The
// sifting loop through the RAM sets the rate. Items are not taken while a
// batch sorts or streams.
// Reset clears the count, the drop flag and the output valid flag; RAM
// contents are not cleared. A stalled receiver holds the result register
// and streaming pauses; once the final result is in the output register
// the block accepts the next batch while that result waits.
module heap_sort_top import hs_pkg::*; (
  input logic      clk,
  input logic      rst,
  hs_in_if.sink    items,
  hs_out_if.source results
);

  hs_state_t state, state_next;

  logic [CNT_W-1:0]  count;
  logic              dropped;
  logic [IDX_W-1:0]  bi;
  logic [IDX_W-1:0]  si;
  logic [IDX_W-1:0]  oi;
  logic [IDX_W-1:0]  node;
  logic [CNT_W-1:0]  limit;
  logic [DATA_W-1:0] val;
  logic              sorting;

  logic              ovalid;
  logic [DATA_W-1:0] odata;
  logic              olast;
  logic              oflow;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_ra;
  logic [IDX_W-1:0]  ram_rb;
  logic [DATA_W-1:0] rd_a;
  logic [DATA_W-1:0] rd_b;

  hs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_ra),
    .rdata_a (rd_a),
    .raddr_b (ram_rb),
    .rdata_b (rd_b)
  );

  // Load side
  logic             in_acc;
  logic             has_room;
  logic [CNT_W-1:0] count_next;

  assign in_acc     = items.valid && items.ready;
  assign has_room   = count < CNT_W'(MAX_ITEMS);
  assign count_next = has_room ? count + CNT_W'(1) : count;

  // Sift datapath: children of the current node, compare against held value
  logic [CNT_W-1:0]  left;
  logic [CNT_W-1:0]  right;
  logic              left_ok;
  logic              right_ok;
  logic              lg;
  logic              rg;
  logic [DATA_W-1:0] bigv0;
  logic [DATA_W-1:0] bigv;
  logic [CNT_W-1:0]  big;
  logic              go_on;
  logic [CNT_W-1:0]  nl;
  logic [CNT_W-1:0]  nr;
  logic              nl_ok;
  logic              swap_ok;
  hs_state_t         done_state;

  assign left     = {node, 1'b1};
  assign right    = left + CNT_W'(1);
  assign left_ok  = left < limit;
  assign right_ok = right < limit;
  assign lg       = value_gt(rd_a, val);
  assign bigv0    = lg ? rd_a : val;
  assign rg       = right_ok && value_gt(rd_b, bigv0);
  assign bigv     = rg ? rd_b : bigv0;
  assign big      = rg ? right : left;
  assign go_on    = lg || rg;
  assign nl       = {big[IDX_W-1:0], 1'b1};
  assign nr       = nl + CNT_W'(1);
  assign nl_ok    = nl < limit;
  assign swap_ok  = CNT_W'(1) < {1'b0, si};
  assign done_state = sorting ? ST_SORT : ST_BUILD;

  // Output side
  logic out_take;
  logic out_load;
  logic olast_now;

  assign out_take  = results.valid && results.ready;
  assign out_load  = (state == ST_OUT) && (!ovalid || results.ready);
  assign olast_now = ({1'b0, oi} + CNT_W'(1)) == count;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:   if (in_acc && items.last) state_next = ST_BUILD;
      ST_BUILD:  state_next = (bi == '0) ? ST_SORT : ST_BVAL;
      ST_BVAL:   state_next = left_ok ? ST_CMP : ST_PLACE;
      ST_SORT:   state_next = (si == '0) ? ST_OUT_RD : ST_SWAP;
      ST_SWAP:   state_next = swap_ok ? ST_CMP : ST_PLACE;
      ST_CMP: begin
        if (!go_on) begin
          state_next = done_state;
        end else begin
          state_next = nl_ok ? ST_CMP : ST_PLACE;
        end
      end
      ST_PLACE:  state_next = done_state;
      ST_OUT_RD: state_next = ST_OUT;
      ST_OUT:    if (out_load && olast_now) state_next = ST_LOAD;
      default:   state_next = ST_LOAD;
    endcase
  end

  // RAM controls and handshake
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node;
    ram_wdata = val;
    ram_ra    = node;
    ram_rb    = node;
    unique case (state)
      ST_LOAD: begin
        ram_we    = in_acc && has_room;
        ram_waddr = count[IDX_W-1:0];
        ram_wdata = items.value;
      end
      ST_BUILD: ram_ra = bi - IDX_W'(1);
      ST_BVAL: begin
        ram_ra = left[IDX_W-1:0];
        ram_rb = right[IDX_W-1:0];
      end
      ST_SORT: begin
        ram_ra = si;
        ram_rb = '0;
      end
      ST_SWAP: begin
        // old root moves to the end; children of the root are fetched
        ram_we    = 1'b1;
        ram_waddr = si;
        ram_wdata = rd_b;
        ram_ra    = IDX_W'(1);
        ram_rb    = IDX_W'(2);
      end
      ST_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = go_on ? bigv : val;
        ram_ra    = nl[IDX_W-1:0];
        ram_rb    = nr[IDX_W-1:0];
      end
      ST_PLACE:  ram_we = 1'b1;
      ST_OUT_RD: ram_ra = oi;
      // fetch the following entry as soon as the current one is loaded
      ST_OUT:    ram_ra = out_load ? oi + IDX_W'(1) : oi;
      default:   ram_we = 1'b0;
    endcase
  end

  assign items.ready          = (state == ST_LOAD);
  assign results.valid        = ovalid;
  assign results.sorted_value = $signed(odata);
  assign results.last_res     = olast;
  assign results.overflow     = oflow;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
      sorting <= 1'b0;
      ovalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_take && !out_load) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            count <= count_next;
            if (!has_room) dropped <= 1'b1;
            if (items.last) sorting <= 1'b0;
          end
        end
        ST_BUILD: if (bi == '0) sorting <= 1'b1;
        ST_OUT: begin
          if (out_load) begin
            ovalid <= 1'b1;
            if (olast_now) begin
              count   <= '0;
              dropped <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_LOAD: begin
        if (in_acc && items.last) begin
          bi    <= IDX_W'(count_next >> 1);
          limit <= count_next;
        end
      end
      ST_BUILD: begin
        if (bi != '0) begin
          node <= bi - IDX_W'(1);
          bi   <= bi - IDX_W'(1);
        end else begin
          si <= IDX_W'(count - CNT_W'(1));
        end
      end
      ST_BVAL: val <= rd_a;
      ST_SORT: oi <= '0;
      ST_SWAP: begin
        val   <= rd_a;
        node  <= '0;
        limit <= {1'b0, si};
        si    <= si - IDX_W'(1);
      end
      ST_CMP: if (go_on) node <= big[IDX_W-1:0];
      ST_OUT: begin
        if (out_load) begin
          odata <= rd_a;
          olast <= olast_now;
          oflow <= dropped;
          oi    <= oi + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("element count above capacity");

  a_node_in_heap: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> {1'b0, node} < limit)
    else $error("sift node outside heap");

  a_no_write_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT || state == ST_OUT_RD) |-> !ram_we)
    else $error("store written while streaming results");

  a_batch_end: assert property (@(posedge clk) disable iff (rst)
    out_load && olast_now |=> state == ST_LOAD && count == '0 && !dropped && ovalid)
    else $error("batch did not close after final result");

endmodule

// ----- tb/sv/heap_sort_checker.sv -----
`timescale 1ns / 1ps
// Sort predictor and result comparator that watches the heap sorter channels.
module heap_sort_checker import hs_pkg::*; (
  input  logic clk,
  input  logic rst,
  hs_in_if     items,
  hs_out_if    results,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_res;
    logic                     overflow;
  } sorted_word_t;

  logic signed [DATA_W-1:0] batch_vals [MAX_ITEMS];
  int                       batch_len;
  bit                       batch_dropped;
  sorted_word_t             sorted_due [$];
  sorted_word_t             head;

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Ascending insertion sort of the held batch, then one expectation per value.
  task automatic queue_sorted_batch();
    logic signed [DATA_W-1:0] key;
    int                       i;
    int                       j;
    sorted_word_t             word;
    for (i = 1; i < batch_len; i++) begin
      key = batch_vals[i];
      j = i - 1;
      while (j >= 0 && batch_vals[j] > key) begin
        batch_vals[j+1] = batch_vals[j];
        j--;
      end
      batch_vals[j+1] = key;
    end
    for (i = 0; i < batch_len; i++) begin
      word.sorted_value = batch_vals[i];
      word.last_res     = (i == batch_len - 1);
      word.overflow     = batch_dropped;
      sorted_due.push_back(word);
    end
    batch_len     = 0;
    batch_dropped = 0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      batch_len     = 0;
      batch_dropped = 0;
      sorted_due.delete();
    end else begin
      // results first: a final result may leave on the edge that closes the next batch
      if (results.valid && results.ready) begin
        if (sorted_due.size() == 0) begin
          report_mismatch("result with nothing expected", results.sorted_value, 0);
        end else begin
          head = sorted_due.pop_front();
          if (results.sorted_value !== head.sorted_value)
            report_mismatch("sorted_value", results.sorted_value, head.sorted_value);
          if (results.last_res !== head.last_res)
            report_mismatch("last_res", results.last_res, head.last_res);
          if (results.overflow !== head.overflow)
            report_mismatch("overflow", results.overflow, head.overflow);
        end
      end
      if (items.valid && items.ready) begin
        if (batch_len < MAX_ITEMS) begin
          batch_vals[batch_len] = items.value;
          batch_len++;
        end else begin
          batch_dropped = 1;
        end
        // a dropped request still closes the batch
        if (items.last)
          queue_sorted_batch();
      end
    end
    pending <= sorted_due.size();
  end

endmodule

// ----- tb/sv/heap_sort_top_tb.sv -----
`timescale 1ns / 1ps
// Stimulus, receiver flow control and verdict for the heap sorter.
module heap_sort_top_tb;
  import hs_pkg::*;

  localparam logic signed [DATA_W-1:0] V_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] V_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam int                       TARGET_ITEMS = 516;
  localparam int                       HOLD_CYCLES  = 600;

  logic clk;
  logic rst;
  int   fail_count;
  int   due_count;
  int   sent;
  int   batch_no;
  bit   calm;
  bit   hold_results;

  hs_in_if  items_ch ();
  hs_out_if results_ch ();

  heap_sort_top dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  heap_sort_checker sort_watch (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .errors  (fail_count),
    .pending (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("[heap_sort_top] ERROR");
    $finish;
  end

  // receiver: random stalls, calm stretch, and one long hold on request
  initial begin
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        results_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 0;
      end
      results_ch.ready <= calm || ($urandom_range(99) >= 31);
    end
  end

  // called at a rising edge; returns at the edge where the request is taken
  task automatic offer(logic signed [DATA_W-1:0] v, logic l);
    items_ch.valid <= 1'b1;
    items_ch.value <= v;
    items_ch.last  <= l;
    do @(posedge clk); while (!items_ch.ready);
    sent++;
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(99) < 31) begin
      items_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    items_ch.valid <= 1'b0;
    @(posedge clk);
    wait (due_count == 0);
    @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return V_MAX;
      1:       return V_MIN;
      2, 3:    return $signed($urandom_range(15)) - 8;  // narrow range -> duplicates
      default: return $urandom;
    endcase
  endfunction

  task automatic send_batch(int n);
    for (int i = 0; i < n; i++) begin
      offer(pick_value(), i == n - 1);
      maybe_pause();
    end
    batch_no++;
  endtask

  task automatic send_list(logic signed [DATA_W-1:0] vals [$]);
    for (int i = 0; i < vals.size(); i++) begin
      offer(vals[i], i == vals.size() - 1);
      maybe_pause();
    end
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 10);
    if (r < 85) return $urandom_range(11, 30);
    if (r < 93) return MAX_ITEMS;
    return $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);  // overflow batch
  endfunction

  initial begin
    sent         = 0;
    batch_no     = 0;
    calm         = 0;
    hold_results = 0;
    rst            <= 1'b1;
    items_ch.valid <= 1'b0;
    items_ch.value <= '0;
    items_ch.last  <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-element batches at both extremes, then short batches with extremes and duplicates
    send_list('{V_MAX});
    send_list('{V_MIN});
    send_list('{32'sd0, -32'sd1, 32'sd1, V_MIN, V_MAX, V_MAX, V_MIN, 32'sd5, 32'sd5,
                -32'sd5});
    send_list('{32'sd3, 32'sd3});
    send_list('{32'sd100, -32'sd100});
    wait_drained();

    // exactly full, then full with the closing request dropped
    send_batch(MAX_ITEMS);
    send_batch(MAX_ITEMS + 2);
    wait_drained();

    while (sent < TARGET_ITEMS) begin
      calm = (sent >= 250 && sent < 340);
      if (batch_no == 6) begin
        // receiver holds off while two batches are offered: input must stall
        hold_results = 1;
        send_batch(8);
        send_batch(8);
      end else begin
        send_batch(pick_size());
      end
      if (batch_no % 7 == 0)
        wait_drained();
    end
    calm = 0;

    items_ch.valid <= 1'b0;
    @(posedge clk);
    wait (due_count == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("[heap_sort_top] OK");
    else
      $display("[heap_sort_top] ERROR");
    $finish;
  end

endmodule

// ----- heap_sort_top.f -----
src/hs_pkg.sv
src/hs_if.sv
src/hs_ram.sv
src/heap_sort_top.sv
tb/sv/heap_sort_checker.sv
tb/sv/heap_sort_top_tb.sv
